// ===== src/ps2mpt_pkg.sv =====
// shared types, constants and register codes for the ps2 mouse cursor tracker
package ps2mpt_pkg;

    // cursor coordinate width
    localparam int COORD_WIDTH = 12;
    localparam int COORD_SPAN  = 1 << COORD_WIDTH;

    // width of the fixed output position ports
    localparam int POS_WIDTH = 12;

    // screen limit register width
    localparam int LIMIT_WIDTH = 13;

    // scaled motion is at most 384 in magnitude
    localparam int MOVE_WIDTH = 11;

    // signed width of cursor plus motion
    localparam int SUM_WIDTH = ((COORD_WIDTH > MOVE_WIDTH) ? COORD_WIDTH : MOVE_WIDTH) + 2;

    // width used to compare a limit against the coordinate span
    localparam int CMP_WIDTH = ((LIMIT_WIDTH > COORD_WIDTH + 1) ? LIMIT_WIDTH
                                                                : COORD_WIDTH + 1);

    // configuration register indexes
    localparam logic [1:0] REG_SENSITIVITY = 2'd0;
    localparam logic [1:0] REG_X_LIMIT     = 2'd1;
    localparam logic [1:0] REG_Y_LIMIT     = 2'd2;

    // sensitivity codes
    localparam logic [1:0] SENS_HALF     = 2'd1;
    localparam logic [1:0] SENS_UNITY    = 2'd2;
    localparam logic [1:0] SENS_ONE_HALF = 2'd3;

    // reset values
    localparam logic [1:0]             SENS_RESET     = SENS_UNITY;
    localparam logic [LIMIT_WIDTH-1:0] X_LIMIT_RESET  = LIMIT_WIDTH'(1024);
    localparam logic [LIMIT_WIDTH-1:0] Y_LIMIT_RESET  = LIMIT_WIDTH'(768);
    localparam logic [COORD_WIDTH-1:0] CURSOR_X_RESET = COORD_WIDTH'(512);
    localparam logic [COORD_WIDTH-1:0] CURSOR_Y_RESET = COORD_WIDTH'(384);

    // status byte bit positions
    localparam int STAT_SYNC_BIT  = 3;
    localparam int STAT_X_NEG_BIT = 4;
    localparam int STAT_Y_NEG_BIT = 5;
    localparam int STAT_X_OVF_BIT = 6;
    localparam int STAT_Y_OVF_BIT = 7;

    // framing phase
    typedef enum logic [1:0] {
        PH_STATUS,
        PH_X_MOVE,
        PH_Y_MOVE
    } phase_t;

    // one framed packet ready for the cursor update
    typedef struct packed {
        logic [2:0] buttons;
        logic       x_neg;
        logic       y_neg;
        logic [7:0] x_move;
        logic [7:0] y_move;
    } packet_t;

    // configuration seen by the cursor update
    typedef struct packed {
        logic [1:0]             sensitivity;
        logic [LIMIT_WIDTH-1:0] x_limit;
        logic [LIMIT_WIDTH-1:0] y_limit;
    } cfg_t;

endpackage

// ===== src/ps2mpt_front.sv =====
// byte framing front end: collects status, x and y bytes into packets
module ps2mpt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic                q_full,
    output logic                push,
    output ps2mpt_pkg::packet_t push_pkt
);

    ps2mpt_pkg::phase_t state_reg;
    ps2mpt_pkg::phase_t state_next;
    logic [7:0]         status_reg;
    logic [7:0]         x_move_reg;
    logic               accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ps2mpt_pkg::PH_STATUS;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept && state_reg == ps2mpt_pkg::PH_STATUS && rx_byte[ps2mpt_pkg::STAT_SYNC_BIT])
        begin
            status_reg <= rx_byte;
        end
        if (accept && state_reg == ps2mpt_pkg::PH_X_MOVE)
        begin
            x_move_reg <= rx_byte;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        if (accept)
        begin
            case (state_reg)
                ps2mpt_pkg::PH_STATUS:
                begin
                    // no sync bit: drop and stay, resyncs framing
                    if (rx_byte[ps2mpt_pkg::STAT_SYNC_BIT])
                    begin
                        state_next = ps2mpt_pkg::PH_X_MOVE;
                    end
                end
                ps2mpt_pkg::PH_X_MOVE:
                begin
                    state_next = ps2mpt_pkg::PH_Y_MOVE;
                end
                ps2mpt_pkg::PH_Y_MOVE:
                begin
                    state_next = ps2mpt_pkg::PH_STATUS;
                    push       = !status_reg[ps2mpt_pkg::STAT_X_OVF_BIT]
                              && !status_reg[ps2mpt_pkg::STAT_Y_OVF_BIT];
                end
                default:
                begin
                    state_next = ps2mpt_pkg::PH_STATUS;
                end
            endcase
        end
    end

    always_comb
    begin
        push_pkt.buttons = status_reg[2:0];
        push_pkt.x_neg   = status_reg[ps2mpt_pkg::STAT_X_NEG_BIT];
        push_pkt.y_neg   = status_reg[ps2mpt_pkg::STAT_Y_NEG_BIT];
        push_pkt.x_move  = x_move_reg;
        push_pkt.y_move  = rx_byte;
    end

    // a packet leaves only on the third byte of a frame
    a_push_on_y: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (state_reg == ps2mpt_pkg::PH_Y_MOVE) && (state_next == ps2mpt_pkg::PH_STATUS))
        else $error("packet pushed outside the y byte");

endmodule

// ===== src/ps2mpt_fifo.sv =====
// two-entry packet queue between framing and cursor update
module ps2mpt_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ps2mpt_pkg::packet_t push_pkt,
    output logic                full,
    input  logic                pop,
    output logic                pkt_valid,
    output ps2mpt_pkg::packet_t pop_pkt
);

    ps2mpt_pkg::packet_t entry_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;

    assign full      = (count_reg == 2'd2);
    assign pkt_valid = (count_reg != 2'd0);
    assign pop_pkt   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pkt_valid)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

// ===== src/ps2mpt_back.sv =====
// cursor update: scales motion, moves and clamps the cursor, holds the result
module ps2mpt_back (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  ps2mpt_pkg::cfg_t                         cfg,
    input  logic                                     pkt_valid,
    input  ps2mpt_pkg::packet_t                      pkt,
    output logic                                     pop,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [ps2mpt_pkg::POS_WIDTH-1:0]         x_position,
    output logic [ps2mpt_pkg::POS_WIDTH-1:0]         y_position,
    output logic [2:0]                               buttons
);

    logic [ps2mpt_pkg::COORD_WIDTH-1:0]        cursor_x_reg;
    logic [ps2mpt_pkg::COORD_WIDTH-1:0]        cursor_y_reg;
    logic [ps2mpt_pkg::COORD_WIDTH-1:0]        cursor_x_next;
    logic [ps2mpt_pkg::COORD_WIDTH-1:0]        cursor_y_next;
    logic                                      out_valid_reg;
    logic [2:0]                                buttons_reg;
    logic signed [ps2mpt_pkg::MOVE_WIDTH-1:0]  dx;
    logic signed [ps2mpt_pkg::MOVE_WIDTH-1:0]  dy;
    logic signed [ps2mpt_pkg::SUM_WIDTH-1:0]   sum_x;
    logic signed [ps2mpt_pkg::SUM_WIDTH-1:0]   sum_y;

    // 9-bit signed move, scaled; halving truncates toward zero
    function automatic logic signed [ps2mpt_pkg::MOVE_WIDTH-1:0] scale_move(
        input logic       neg,
        input logic [7:0] low,
        input logic [1:0] sens
    );
        logic signed [8:0]                        m;
        logic signed [9:0]                        rounded;
        logic signed [8:0]                        half;
        logic signed [ps2mpt_pkg::MOVE_WIDTH-1:0] res;
        m       = $signed({neg, low});
        rounded = 10'(m) + $signed({9'd0, neg});
        half    = 9'(rounded >>> 1);
        case (sens)
            ps2mpt_pkg::SENS_ONE_HALF: res = ps2mpt_pkg::MOVE_WIDTH'(m)
                                           + ps2mpt_pkg::MOVE_WIDTH'(half);
            ps2mpt_pkg::SENS_UNITY:    res = ps2mpt_pkg::MOVE_WIDTH'(m);
            default:                   res = ps2mpt_pkg::MOVE_WIDTH'(half);
        endcase
        return res;
    endfunction

    // largest allowed coordinate for a screen limit
    function automatic logic [ps2mpt_pkg::COORD_WIDTH-1:0] limit_top(
        input logic [ps2mpt_pkg::LIMIT_WIDTH-1:0] lim
    );
        logic [ps2mpt_pkg::COORD_WIDTH-1:0] top;
        if (lim == '0)
        begin
            top = '0;
        end
        else if (ps2mpt_pkg::CMP_WIDTH'(lim) > ps2mpt_pkg::CMP_WIDTH'(ps2mpt_pkg::COORD_SPAN))
        begin
            top = '1;
        end
        else
        begin
            top = ps2mpt_pkg::COORD_WIDTH'(lim - ps2mpt_pkg::LIMIT_WIDTH'(1));
        end
        return top;
    endfunction

    function automatic logic [ps2mpt_pkg::COORD_WIDTH-1:0] clamp(
        input logic signed [ps2mpt_pkg::SUM_WIDTH-1:0] v,
        input logic [ps2mpt_pkg::COORD_WIDTH-1:0]      top
    );
        logic [ps2mpt_pkg::SUM_WIDTH-1:0]   top_ext;
        logic [ps2mpt_pkg::COORD_WIDTH-1:0] res;
        top_ext = ps2mpt_pkg::SUM_WIDTH'(top);
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > $signed(top_ext))
        begin
            res = top;
        end
        else
        begin
            res = ps2mpt_pkg::COORD_WIDTH'(v);
        end
        return res;
    endfunction

    assign pop = pkt_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        dx    = scale_move(pkt.x_neg, pkt.x_move, cfg.sensitivity);
        dy    = scale_move(pkt.y_neg, pkt.y_move, cfg.sensitivity);
        sum_x = $signed({1'b0, (ps2mpt_pkg::SUM_WIDTH-1)'(cursor_x_reg)})
              + ps2mpt_pkg::SUM_WIDTH'(dx);
        sum_y = $signed({1'b0, (ps2mpt_pkg::SUM_WIDTH-1)'(cursor_y_reg)})
              - ps2mpt_pkg::SUM_WIDTH'(dy);
        cursor_x_next = clamp(sum_x, limit_top(cfg.x_limit));
        cursor_y_next = clamp(sum_y, limit_top(cfg.y_limit));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= ps2mpt_pkg::CURSOR_X_RESET;
            cursor_y_reg  <= ps2mpt_pkg::CURSOR_Y_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cursor_x_reg  <= cursor_x_next;
                cursor_y_reg  <= cursor_y_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            buttons_reg <= pkt.buttons;
        end
    end

    assign out_valid  = out_valid_reg;
    assign x_position = ps2mpt_pkg::POS_WIDTH'(cursor_x_reg);
    assign y_position = ps2mpt_pkg::POS_WIDTH'(cursor_y_reg);
    assign buttons    = buttons_reg;

    // a held result is never overwritten by a new packet
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("result overwritten while stalled");

endmodule

// ===== src/ps2_mouse_packet_cursor_tracker.sv =====
// top level of the ps2 mouse packet decoder with cursor tracking
//
// takes one received ps2 mouse byte per word on the input channel and frames
// them into 3-byte packets (status, x move, y move); a status byte without
// bit 3 set is dropped, which resyncs framing, and a packet with either
// overflow bit set is consumed without a result. each good packet scales its
// 9-bit signed x and y moves by the sensitivity setting, adds x to and
// subtracts y from the cursor, clamps it to 0..limit-1 (at most 4095) and
// emits one output word with the position and the three button bits. a byte
// is taken every cycle while the two-entry packet queue has room; the cursor
// update retires one packet per cycle into the output register when that is
// empty or being read. the user must write the registers through the cfg
// port only while the block is idle; the block itself does not enforce it.
module ps2_mouse_packet_cursor_tracker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_write,
    input  logic [1:0]                             cfg_index,
    input  logic [ps2mpt_pkg::LIMIT_WIDTH-1:0]     cfg_data,
    // input byte words
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [7:0]                             rx_byte,
    // result words
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [ps2mpt_pkg::POS_WIDTH-1:0]       x_position,
    output logic [ps2mpt_pkg::POS_WIDTH-1:0]       y_position,
    output logic [2:0]                             buttons
);

    ps2mpt_pkg::cfg_t    cfg_reg;
    ps2mpt_pkg::packet_t push_pkt;
    ps2mpt_pkg::packet_t pop_pkt;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                pkt_valid;

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensitivity <= ps2mpt_pkg::SENS_RESET;
            cfg_reg.x_limit     <= ps2mpt_pkg::X_LIMIT_RESET;
            cfg_reg.y_limit     <= ps2mpt_pkg::Y_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ps2mpt_pkg::REG_SENSITIVITY: cfg_reg.sensitivity <= cfg_data[1:0];
                ps2mpt_pkg::REG_X_LIMIT:     cfg_reg.x_limit     <= cfg_data;
                ps2mpt_pkg::REG_Y_LIMIT:     cfg_reg.y_limit     <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // framing front end
    ps2mpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .push     (push),
        .push_pkt (push_pkt)
    );

    // packet queue decouples framing from the cursor update
    ps2mpt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_pkt  (push_pkt),
        .full      (q_full),
        .pop       (pop),
        .pkt_valid (pkt_valid),
        .pop_pkt   (pop_pkt)
    );

    // cursor update and output register
    ps2mpt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pkt_valid  (pkt_valid),
        .pkt        (pop_pkt),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .x_position (x_position),
        .y_position (y_position),
        .buttons    (buttons)
    );

endmodule
